FILE: hdl/lzssw_pkg.sv
// Shared types and constants of the LZSS window decoder.
package lzssw_pkg;

   localparam int CODE_W     = 8;
   localparam int POS_W      = 11;
   localparam int LEN_W      = 16;
   localparam int CNT_W      = 17;
   localparam int COPY_W     = 6;
   localparam int FLAG_W     = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [POS_W-1:0]     START_RESET        = 11'h7DE;
   localparam logic [COPY_W-1:0]    MIN_COPY           = 6'd3;
   localparam logic [FLAG_W-1:0]    FLAGS_PER_BYTE     = 4'd8;
   localparam logic [CNT_W-1:0]     CNT_MAX            = 17'h1FFFF;
   localparam logic [REG_IDX_W-1:0] REG_START_POSITION = 1'b0;

   typedef enum logic [2:0] {
      PH_LEN_LO = 3'd0,
      PH_LEN_HI = 3'd1,
      PH_FLAG   = 3'd2,
      PH_TOKEN  = 3'd3,
      PH_REF_HI = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_READ,
      SQ_EMIT
   } seq_type;

endpackage

FILE: hdl/lzssw_ifs.sv
// Request and response channel interfaces of the LZSS window decoder.
interface lzssw_req_if;
   logic                             valid;
   logic                             ready;
   logic [lzssw_pkg::CODE_W-1:0]     code_byte;

   modport source (output valid, output code_byte, input ready);
   modport sink (input valid, input code_byte, output ready);
endinterface

interface lzssw_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lzssw_pkg::CODE_W-1:0]     data_byte;
   logic                             run_last;
   logic                             stream_end;

   modport source (output valid, output data_byte, output run_last, output stream_end,
                   input ready);
   modport sink (input valid, input data_byte, input run_last, input stream_end,
                 output ready);
endinterface

FILE: hdl/lzssw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzssw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lzss_window_decoder_top.sv
// Top level of the LZSS window decoder: parser, copy sequencer, window and CSR.
//
//  channel   direction  handshake          payload
//  req_bus   in         valid/ready        code_byte
//  rsp_bus   out        valid/ready        data_byte, run_last, stream_end
//  csr       in/out     APB psel/penable   start_position at byte address 0
//
// Header, flag, reference-low and literal bytes are each accepted while the sequencer is idle.
// A reference copies 3 to 34 bytes, each as a window RAM read (SQ_READ) followed
// by an emit/write step (SQ_EMIT), repeated through the single RAM port pair.
// Reset clears control state only; the window needs no clearing pass, since a
// fill count since stream start marks which entries read as zero.
// A stalled response holds the sequencer in its emit step; req_bus.ready is low
// while a reference is being copied or the output register cannot be freed.
module lzss_window_decoder_top #(
   parameter int WINDOW_DEPTH = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   lzssw_req_if.sink                          req_bus,
   lzssw_rsp_if.source                        rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lzssw_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lzssw_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lzssw_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                               pready
);
   import lzssw_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);

   // configuration
   logic [AW-1:0]        start_pos_ff, start_pos_in;
   logic [REG_IDX_W-1:0] reg_idx;

   // parser state
   phase_type            phase_ff, phase_in;
   logic [CODE_W-1:0]    flag_ff, flag_in;
   logic [FLAG_W-1:0]    rem_ff, rem_in;
   logic [LEN_W-1:0]     total_ff, total_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CODE_W-1:0]    ref_low_ff, ref_low_in;

   // window bookkeeping
   logic [AW-1:0]        wp_ff, wp_in;
   logic [AW-1:0]        base_ff, base_in;
   logic [AW:0]          fill_ff, fill_in;

   // copy sequencer
   seq_type              seq_ff, seq_in;
   logic [AW-1:0]        src_ff, src_in;
   logic [COPY_W-1:0]    len_ff, len_in;
   logic                 rd_valid_ff, rd_valid_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]    out_data_ff, out_data_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_end_ff, out_end_in;

   // combinational
   logic                 req_accept;
   logic                 out_free;
   logic [CNT_W-1:0]     cnt_inc;
   logic [CODE_W-1:0]    flag_shift;
   logic [FLAG_W-1:0]    rem_dec;
   logic [LEN_W-1:0]     ref_word;
   logic [AW-1:0]        rd_dist;
   logic                 ram_we;
   logic                 ram_re;
   logic [CODE_W-1:0]    ram_wdata;
   logic [CODE_W-1:0]    ram_rdata;
   logic [CODE_W-1:0]    copy_byte;
   logic                 copy_last;
   logic                 at_end;

   lzssw_ram #(
      .WIDTH (CODE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (src_ff),
      .rd_data (ram_rdata)
   );

   // CSR port
   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      start_pos_in = start_pos_ff;
      if (psel && penable && pwrite && reg_idx == REG_START_POSITION) begin
         start_pos_in = pwdata[AW-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == REG_START_POSITION) begin
         prdata = CSR_DATA_W'(start_pos_ff);
      end
   end

   // handshakes
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (seq_ff == SQ_IDLE) && out_free;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.data_byte  = out_data_ff;
   assign rsp_bus.run_last   = out_last_ff;
   assign rsp_bus.stream_end = out_end_ff;

   // shared helpers
   assign cnt_inc    = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
   assign flag_shift = flag_ff >> 1;
   assign rem_dec    = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
   assign ref_word   = {req_bus.code_byte, ref_low_ff};
   assign rd_dist    = src_ff - base_ff;
   assign copy_byte  = rd_valid_ff ? ram_rdata : '0;
   assign copy_last  = (len_ff == COPY_W'(1));

   // next sequencer state
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SQ_IDLE: begin
            if (req_accept && phase_ff == PH_REF_HI) begin
               seq_in = SQ_READ;
            end
         end
         SQ_READ: seq_in = SQ_EMIT;
         SQ_EMIT: begin
            if (out_free) begin
               seq_in = copy_last ? SQ_IDLE : SQ_READ;
            end
         end
         default: seq_in = SQ_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in     = phase_ff;
      flag_in      = flag_ff;
      rem_in       = rem_ff;
      total_in     = total_ff;
      cnt_in       = cnt_ff;
      ref_low_in   = ref_low_ff;
      wp_in        = wp_ff;
      base_in      = base_ff;
      fill_in      = fill_ff;
      src_in       = src_ff;
      len_in       = len_ff;
      rd_valid_in  = rd_valid_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_wdata    = req_bus.code_byte;
      at_end       = 1'b0;

      unique case (seq_ff)
         SQ_IDLE: begin
            if (req_accept) begin
               unique case (phase_ff)
                  PH_LEN_LO: begin
                     wp_in    = start_pos_ff;
                     base_in  = start_pos_ff;
                     fill_in  = '0;
                     flag_in  = '0;
                     rem_in   = '0;
                     total_in = LEN_W'(req_bus.code_byte);
                     cnt_in   = CNT_W'(1);
                     phase_in = PH_LEN_HI;
                  end
                  PH_LEN_HI: begin
                     total_in = {req_bus.code_byte, total_ff[CODE_W-1:0]};
                     cnt_in   = cnt_inc;
                     phase_in = (cnt_inc >= CNT_W'(total_in)) ? PH_LEN_LO : PH_FLAG;
                  end
                  PH_FLAG: begin
                     flag_in  = req_bus.code_byte;
                     rem_in   = FLAGS_PER_BYTE;
                     cnt_in   = cnt_inc;
                     phase_in = PH_TOKEN;
                  end
                  PH_TOKEN: begin
                     cnt_in = cnt_inc;
                     if (flag_ff[0]) begin
                        at_end       = cnt_inc >= CNT_W'(total_ff);
                        ram_we       = 1'b1;
                        wp_in        = wp_ff + 1'b1;
                        fill_in      = (fill_ff == (AW+1)'(WINDOW_DEPTH)) ?
                                       fill_ff : fill_ff + 1'b1;
                        out_valid_in = 1'b1;
                        out_data_in  = req_bus.code_byte;
                        out_last_in  = 1'b1;
                        out_end_in   = at_end;
                        flag_in      = flag_shift;
                        rem_in       = rem_dec;
                        phase_in     = at_end ? PH_LEN_LO :
                                       ((rem_dec != '0) ? PH_TOKEN : PH_FLAG);
                     end else begin
                        ref_low_in = req_bus.code_byte;
                        phase_in   = PH_REF_HI;
                     end
                  end
                  PH_REF_HI: begin
                     cnt_in = cnt_inc;
                     src_in = AW'(ref_word[POS_W-1:0]);
                     len_in = COPY_W'(ref_word[LEN_W-1:POS_W]) + MIN_COPY;
                  end
                  default: phase_in = PH_LEN_LO;
               endcase
            end
         end
         SQ_READ: begin
            ram_re = 1'b1;
            // entries not yet written since stream start read as zero
            rd_valid_in = {1'b0, rd_dist} < fill_ff;
         end
         SQ_EMIT: begin
            if (out_free) begin
               at_end       = cnt_ff >= CNT_W'(total_ff);
               ram_we       = 1'b1;
               ram_wdata    = copy_byte;
               wp_in        = wp_ff + 1'b1;
               fill_in      = (fill_ff == (AW+1)'(WINDOW_DEPTH)) ? fill_ff : fill_ff + 1'b1;
               out_valid_in = 1'b1;
               out_data_in  = copy_byte;
               out_last_in  = copy_last;
               out_end_in   = copy_last && at_end;
               src_in       = src_ff + 1'b1;
               len_in       = len_ff - 1'b1;
               if (copy_last) begin
                  flag_in  = flag_shift;
                  rem_in   = rem_dec;
                  phase_in = at_end ? PH_LEN_LO : ((rem_dec != '0) ? PH_TOKEN : PH_FLAG);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pos_ff <= AW'(START_RESET);
         phase_ff     <= PH_LEN_LO;
         flag_ff      <= '0;
         rem_ff       <= '0;
         total_ff     <= '0;
         cnt_ff       <= '0;
         ref_low_ff   <= '0;
         wp_ff        <= AW'(START_RESET);
         base_ff      <= AW'(START_RESET);
         fill_ff      <= '0;
         seq_ff       <= SQ_IDLE;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         start_pos_ff <= start_pos_in;
         phase_ff     <= phase_in;
         flag_ff      <= flag_in;
         rem_ff       <= rem_in;
         total_ff     <= total_in;
         cnt_ff       <= cnt_in;
         ref_low_ff   <= ref_low_in;
         wp_ff        <= wp_in;
         base_ff      <= base_in;
         fill_ff      <= fill_in;
         seq_ff       <= seq_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      rd_valid_ff <= rd_valid_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
   end

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (AW+1)'(WINDOW_DEPTH))
      else $error("window fill count beyond depth");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_end_ff |-> out_last_ff)
      else $error("stream end without run end");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_end_ff && seq_ff == SQ_IDLE |-> phase_ff == PH_LEN_LO)
      else $error("stream ended but parser not at header");

   a_copy_len: assert property (@(posedge clock) disable iff (reset)
      seq_ff != SQ_IDLE |-> len_ff != '0)
      else $error("copy running with zero length");

endmodule

FILE: tb/lzssw_tb_pkg.sv
// Scoreboard class: predicts the decoded byte stream and checks the response channel.
package lzssw_tb_pkg;
   import lzssw_pkg::*;

   localparam int WINDOW_BYTES = 1 << POS_W;

   typedef struct packed {
      logic [CODE_W-1:0] data_byte;
      logic              run_last;
      logic              stream_end;
   } decoded_byte_type;

   class decode_scoreboard;
      logic [CODE_W-1:0] history [WINDOW_BYTES];
      logic [POS_W-1:0]  start_position;
      logic [POS_W-1:0]  write_pos;
      logic [CODE_W-1:0] flag_bits;
      logic [FLAG_W-1:0] flags_left;
      phase_type         phase;
      logic [LEN_W-1:0]  total_len;
      logic [CNT_W-1:0]  consumed;
      logic [CODE_W-1:0] ref_low;
      decoded_byte_type  expected_bytes[$];
      int                mismatches;

      function new();
         foreach (history[i]) history[i] = '0;
         start_position = START_RESET;
         write_pos      = START_RESET;
         flag_bits      = '0;
         flags_left     = '0;
         phase          = PH_LEN_LO;
         total_len      = '0;
         consumed       = '0;
         ref_low        = '0;
         mismatches     = 0;
      endfunction

      function void set_start_position(input logic [POS_W-1:0] value);
         start_position = value;
      endfunction

      function void count_code();
         if (consumed != CNT_MAX) consumed++;
      endfunction

      function void emit_byte(input logic [CODE_W-1:0] value);
         decoded_byte_type entry;
         history[write_pos] = value;
         write_pos++;
         entry.data_byte  = value;
         entry.run_last   = 1'b0;
         entry.stream_end = 1'b0;
         expected_bytes.push_back(entry);
      endfunction

      // last byte of a token carries run_last; apart from the header check, the length check happens here
      function void close_token();
         decoded_byte_type tail;
         flag_bits = flag_bits >> 1;
         if (flags_left != 0) flags_left--;
         tail = expected_bytes.pop_back();
         tail.run_last = 1'b1;
         if (consumed >= total_len) begin
            tail.stream_end = 1'b1;
            phase = PH_LEN_LO;
         end else begin
            phase = (flags_left != 0) ? PH_TOKEN : PH_FLAG;
         end
         expected_bytes.push_back(tail);
      endfunction

      function void note_request(input logic [CODE_W-1:0] code);
         logic [LEN_W-1:0] ref_word;
         logic [POS_W-1:0] src;
         int               copy_len;
         unique case (phase)
            PH_LEN_LO: begin
               foreach (history[i]) history[i] = '0;
               write_pos  = start_position;
               flag_bits  = '0;
               flags_left = '0;
               total_len  = {8'h00, code};
               consumed   = 1;
               phase      = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               total_len[15:8] = code;
               count_code();
               phase = (consumed >= total_len) ? PH_LEN_LO : PH_FLAG;
            end
            PH_FLAG: begin
               flag_bits  = code;
               flags_left = FLAGS_PER_BYTE;
               count_code();
               phase = PH_TOKEN;
            end
            PH_TOKEN: begin
               count_code();
               if (flag_bits[0]) begin
                  emit_byte(code);
                  close_token();
               end else begin
                  ref_low = code;
                  phase   = PH_REF_HI;
               end
            end
            PH_REF_HI: begin
               ref_word = {code, ref_low};
               copy_len = int'(ref_word[15:POS_W]) + int'(MIN_COPY);
               src      = ref_word[POS_W-1:0];
               count_code();
               // byte by byte, so a copy may read what it just wrote
               for (int i = 0; i < copy_len; i++) begin
                  emit_byte(history[src]);
                  src++;
               end
               close_token();
            end
            default: phase = PH_LEN_LO;
         endcase
      endfunction

      function void note_mismatch(input string what);
         mismatches++;
         if (mismatches <= 10) $display("%s", what);
      endfunction

      function void check_response(input decoded_byte_type got);
         decoded_byte_type want;
         if (expected_bytes.size() == 0) begin
            note_mismatch($sformatf("unexpected byte: data %02h last %0b end %0b",
                                    got.data_byte, got.run_last, got.stream_end));
         end else begin
            want = expected_bytes.pop_front();
            if (got !== want)
               note_mismatch($sformatf(
                  "byte mismatch: expected %02h last %0b end %0b, got %02h last %0b end %0b",
                  want.data_byte, want.run_last, want.stream_end,
                  got.data_byte, got.run_last, got.stream_end));
         end
      endfunction
   endclass

endpackage

FILE: tb/tb_top.sv
// Testbench top: drives code streams and CSR writes with readback into the LZSS window decoder.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lzssw_pkg::*;
   import lzssw_tb_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] START_POSITION_ADDR = {REG_START_POSITION, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   lzssw_req_if req_bus ();
   lzssw_rsp_if rsp_bus ();

   lzss_window_decoder_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   decode_scoreboard sb = new();
   int burst_left = 0;
   int sent_count = 0;
   int stall_cycle = 0;
   int stall_mode = 0;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // response side stalls on its own pattern, in one of four randomly chosen modes
   always @(negedge clock) begin
      if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      stall_cycle++;
      unique case (stall_mode)
         0:       rsp_bus.ready <= 1'b1;
         1:       rsp_bus.ready <= ($urandom_range(0, 9) >= 3);
         2:       rsp_bus.ready <= ($urandom_range(0, 9) >= 7);
         default: rsp_bus.ready <= (stall_cycle[1:0] != 2'b00);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_response('{rsp_bus.data_byte, rsp_bus.run_last, rsp_bus.stream_end});
   end

   task automatic send_code(input logic [CODE_W-1:0] code);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15)
                                           : $urandom_range(0, 2);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      req_bus.valid     <= 1'b1;
      req_bus.code_byte <= code;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(code);
      burst_left--;
      sent_count++;
   endtask

   // stops early once the parser is back at a header; with finish_stream set, pads a stream that declared more
   task automatic send_stream(input logic [CODE_W-1:0] code[$], input bit finish_stream);
      foreach (code[i]) begin
         send_code(code[i]);
         if (sb.phase == PH_LEN_LO) break;
      end
      if (finish_stream)
         while (sb.phase != PH_LEN_LO) send_code(8'($urandom_range(0, 255)));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [POS_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= START_POSITION_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_start_position(value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[POS_W-1:0] !== value)
         sb.note_mismatch($sformatf("start_position readback: expected %03h, got %03h",
                                    value, prdata[POS_W-1:0]));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic build_stream(input int n_tokens, input bit noise, input bit broken,
                               output logic [CODE_W-1:0] code[$]);
      logic [CODE_W-1:0] flags;
      logic [LEN_W-1:0]  ref_word;
      int                produced;
      int                stream_len;
      int                reach;
      code = {};
      code.push_back(8'h00);
      code.push_back(8'h00);
      produced = 0;
      if (noise) begin
         repeat ($urandom_range(0, 40)) code.push_back(8'($urandom_range(0, 255)));
      end else begin
         while (n_tokens > 0) begin
            flags = 8'($urandom_range(0, 255));
            code.push_back(flags);
            for (int k = 0; k < 8 && n_tokens > 0; k++) begin
               if (flags[k]) begin
                  code.push_back(8'($urandom_range(0, 255)));
                  produced++;
               end else begin
                  ref_word[15:POS_W] = ($urandom_range(0, 3) != 0)
                                       ? 5'($urandom_range(0, 4))
                                       : 5'($urandom_range(0, 31));
                  // mostly point just behind the write position, often overlapping the copy
                  if (produced > 0 && $urandom_range(0, 2) != 0) begin
                     reach = (produced < 8) ? produced : 8;
                     ref_word[POS_W-1:0] =
                        POS_W'(sb.start_position + produced - $urandom_range(1, reach));
                  end else begin
                     ref_word[POS_W-1:0] = POS_W'($urandom_range(0, WINDOW_BYTES - 1));
                  end
                  code.push_back(ref_word[7:0]);
                  code.push_back(ref_word[15:8]);
                  produced += int'(ref_word[15:POS_W]) + int'(MIN_COPY);
               end
               n_tokens--;
            end
         end
      end
      stream_len = noise ? $urandom_range(0, 40) : code.size();
      if (broken) stream_len = $urandom_range(0, code.size() + 6);
      code[0] = 8'(stream_len);
      code[1] = 8'(stream_len >> 8);
   endtask

   initial begin
      logic [CODE_W-1:0] code[$];
      int                kind;
      int                phase_end;
      logic [POS_W-1:0]  setting;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.code_byte = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short lengths: header only, no output
      send_stream({8'h00, 8'h00}, 1'b0);
      send_stream({8'h01, 8'h00}, 1'b0);
      send_stream({8'h02, 8'h00}, 1'b0);
      // count already reached after the flag byte, one token still follows
      send_stream({8'h03, 8'h00, 8'h01, 8'hFF}, 1'b0);
      // literal, then start_position changed mid-stream, then a 34-byte overlapping copy
      // and a 3-byte copy that wraps the window
      send_stream({8'h08, 8'h00, 8'h01, 8'h5A}, 1'b0);
      drain_results();
      csr_write(11'h7FF);
      send_stream({8'hDE, 8'hFF, 8'hFF, 8'h07}, 1'b0);
      // new start position at the top of the window, copy across the wrap
      send_stream({8'h07, 8'h00, 8'h03, 8'h00, 8'hFF, 8'hFF, 8'h0F}, 1'b0);

      for (int p = 0; p < 4; p++) begin
         drain_results();
         unique case (p)
            0:       setting = '0;
            1:       setting = '1;
            2:       setting = POS_W'($urandom_range(1, WINDOW_BYTES - 2));
            default: setting = START_RESET;
         endcase
         csr_write(setting);
         phase_end = sent_count + 18;
         while (sent_count < phase_end) begin
            kind = $urandom_range(0, 19);
            build_stream($urandom_range(1, 12), kind >= 17, kind >= 14 && kind < 17, code);
            send_stream(code, 1'b1);
            if ($urandom_range(0, 7) == 0) drain_results();
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
